/* src/bjcc_pkg.sv */
// ----------------------------------------------------------------------------
// bjcc_pkg
// Shared widths, codes and reset values of the blocked jump chain counter.
// ----------------------------------------------------------------------------
package bjcc_pkg;

  localparam int POS_W   = 10;  // position field
  localparam int JUMP_W  = 11;  // jump field and jump table entries
  localparam int REG_W   = 11;  // configuration registers
  localparam int HOPS_W  = 11;  // hops to block exit
  localparam int TOTAL_W = 11;  // query result

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam int RST_ENTRY_COUNT = 1024;
  localparam int RST_BLOCK_SIZE  = 33;

  // command codes
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b1;

endpackage

/* src/bjcc_if.sv */
// ----------------------------------------------------------------------------
// bjcc_in_if / bjcc_out_if
// Valid/ready channels for command items and query results.
// ----------------------------------------------------------------------------
interface bjcc_in_if;
  import bjcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [POS_W-1:0]  position;
  logic [JUMP_W-1:0] jump;

  modport source (output valid, output command, output position, output jump, input ready);
  modport sink   (input valid, input command, input position, input jump, output ready);
endinterface

interface bjcc_out_if;
  import bjcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] jump_total;

  modport source (output valid, output jump_total, input ready);
  modport sink   (input valid, input jump_total, output ready);
endinterface

/* src/bjcc_rem_div.sv */
// ----------------------------------------------------------------------------
// bjcc_rem_div
// Restoring divider that yields the remainder of a position by the block
// size, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bjcc_rem_div #(
  parameter int DIV_W = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bjcc_pkg::POS_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          rem
);
  import bjcc_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] num_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W:0]   part;
  logic [DIV_W:0]   part_sub;

  assign part     = {rem_r, num_r[POS_W-1]};
  assign part_sub = part - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(POS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      // subtract when the partial remainder reaches the divisor
      if (part >= {1'b0, divisor}) begin
        rem_r <= part_sub[DIV_W-1:0];
      end else begin
        rem_r <= part[DIV_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* src/blocked_jump_chain_counter.sv */
// ----------------------------------------------------------------------------
// blocked_jump_chain_counter
// Jump table split into blocks, with per-entry hops to block exit and exit
// landing, kept in two single-port-write synchronous memories.
// ----------------------------------------------------------------------------
// Use: items arrive on in_ch (command, position, jump); a query item gives
// one jump_total item on out_ch, a write item gives none. The user must
// write entry_count/block_size (cfg_we/cfg_index/cfg_wdata) only while idle
// and rewrite every entry after a change; the block enforces neither.
// Write: the jump is stored at accept, then the block start is found by a
// bit-serial remainder and the entries of the block below entry_count are
// rebuilt right to left at one entry per cycle.
// Query: one stored chain hop per cycle, where the number of hops is at most
// about entry_count / block_size.
// Reset: a clearing pass writes all TABLE_DEPTH entries, one per cycle,
// with in_ch.ready low; configuration writes are taken during it.
// Stall: a result waits in the output register while the next item is
// accepted; a following query result holds the block until it is taken.
// ----------------------------------------------------------------------------
module blocked_jump_chain_counter #(
  parameter int TABLE_DEPTH = bjcc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bjcc_in_if.sink                       in_ch,
  bjcc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [bjcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bjcc_pkg::REG_W-1:0]     cfg_wdata
);
  import bjcc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = ((IW > REG_W) ? IW : REG_W) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);
  localparam int RST_N_USED  = (RST_ENTRY_COUNT > TABLE_DEPTH) ? TABLE_DEPTH : RST_ENTRY_COUNT;
  localparam int RST_BS_USED = (RST_BLOCK_SIZE > TABLE_DEPTH) ? TABLE_DEPTH : RST_BLOCK_SIZE;
  localparam logic [XW-1:0] RST_N_X  = XW'(RST_N_USED);
  localparam logic [XW-1:0] RST_BS_X = XW'(RST_BS_USED);

  typedef struct packed {
    logic [HOPS_W-1:0] hops;
    logic [IW-1:0]     land;
  } chain_t;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_DIV     = 6'b000100,
    S_REBUILD = 6'b001000,
    S_QUERY   = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  // memories
  logic [JUMP_W-1:0] jump_mem [TABLE_DEPTH];
  chain_t            chain_mem [TABLE_DEPTH];

  state_t state_r, state_nxt;

  logic [REG_W-1:0] cfg_entry_count_r;
  logic [REG_W-1:0] cfg_block_size_r;
  logic [XW-1:0]    entry_x, bsz_x, n_x, bs_x;
  logic [IW-1:0]    bs_used;

  logic             in_acc;
  logic [XW-1:0]    pos_x;
  logic             pos_in_table, pos_in_use;
  logic [POS_W-1:0] pos_r;

  // clearing pass
  logic [AW-1:0] clr_p_r;
  logic [IW-1:0] clr_end_r;
  logic [XW-1:0] clr_p_x, clr_hops_x, clr_end_sum;
  chain_t        clr_word;
  logic          clr_last;

  // divider
  logic          div_start, div_done;
  logic [IW-1:0] div_rem;
  logic [XW-1:0] lo_x, end_sum, end_x;
  logic          rb_start;

  // rebuild pipeline
  logic [AW-1:0]     blk_lo_r;
  logic [IW-1:0]     blk_end_r;
  logic              iss_r;
  logic [AW-1:0]     kj_r;
  logic              t_vld_r;
  logic [AW-1:0]     t_k_r;
  logic [JUMP_W-1:0] jrd_r;
  logic [XW-1:0]     t_x, t_land_x;
  logic              t_exit;
  logic              w_vld_r, w_exit_r, w_fwd_r;
  logic [AW-1:0]     w_k_r;
  logic [IW-1:0]     w_land_r;
  chain_t            prev_wr_r, w_src, w_word;
  logic              rb_last;

  // query
  chain_t             crd_r;
  logic [IW-1:0]      q_x_r;
  logic [TOTAL_W-1:0] q_total_r, q_total_nxt;
  logic [TOTAL_W:0]   q_sum;
  logic               q_stop;

  // memory ports
  logic              jm_we;
  logic [AW-1:0]     jm_waddr;
  logic [JUMP_W-1:0] jm_wdata;
  logic              cm_we;
  logic [AW-1:0]     cm_waddr;
  chain_t            cm_wdata;
  logic [AW-1:0]     cm_raddr;

  // output register
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_load;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entry_count_r <= REG_W'(RST_ENTRY_COUNT);
      cfg_block_size_r  <= REG_W'(RST_BLOCK_SIZE);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: cfg_entry_count_r <= cfg_wdata;
        CFG_BLOCK_SIZE:  cfg_block_size_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    entry_x = XW'(cfg_entry_count_r);
    bsz_x   = XW'(cfg_block_size_r);
    n_x     = (entry_x > DEPTH_X) ? DEPTH_X : entry_x;
    if (bsz_x == '0) begin
      bs_x = XW'(1);
    end else if (bsz_x > DEPTH_X) begin
      bs_x = DEPTH_X;
    end else begin
      bs_x = bsz_x;
    end
    bs_used = bs_x[IW-1:0];
  end

  // ---------------- input side ----------------
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign pos_x        = XW'(in_ch.position);
  assign pos_in_table = (pos_x < DEPTH_X);
  assign pos_in_use   = (pos_x < n_x);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r <= in_ch.position;
    end
  end

  // ---------------- clearing pass ----------------
  always_comb begin
    clr_p_x     = XW'(clr_p_r);
    clr_hops_x  = XW'(clr_end_r) - clr_p_x;
    clr_end_sum = XW'(clr_end_r) + RST_BS_X;
    clr_last    = (clr_p_r == AW'(TABLE_DEPTH - 1));
    if (clr_p_x < RST_N_X) begin
      clr_word.hops = clr_hops_x[HOPS_W-1:0];
      clr_word.land = clr_end_r;
    end else begin
      clr_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_p_r   <= '0;
      clr_end_r <= IW'(RST_BS_USED);
    end else if (state_r == S_CLEAR) begin
      clr_p_r <= clr_p_r + AW'(1);
      // advance to the next block end at the last entry of a block
      if ((clr_p_x + XW'(1) == XW'(clr_end_r)) && (XW'(clr_end_r) < RST_N_X)) begin
        clr_end_r <= (clr_end_sum > RST_N_X) ? IW'(RST_N_USED) : clr_end_sum[IW-1:0];
      end
    end
  end

  // ---------------- block start ----------------
  // a write past entry_count still rebuilds the used part of its block
  assign div_start = in_acc && (in_ch.command == CMD_WRITE) && pos_in_table;

  bjcc_rem_div #(
    .DIV_W (IW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_ch.position),
    .divisor  (bs_used),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    lo_x    = XW'(pos_r) - XW'(div_rem);
    end_sum = lo_x + bs_x;
    end_x   = (end_sum > n_x) ? n_x : end_sum;
  end

  assign rb_start = (state_r == S_DIV) && div_done && (lo_x < n_x);

  // ---------------- rebuild pipeline ----------------
  // stage T: jump data back, form target and read its chain entry
  always_comb begin
    t_x      = XW'(t_k_r) + XW'(jrd_r);
    t_exit   = (t_x >= XW'(blk_end_r));
    t_land_x = (t_x > n_x) ? n_x : t_x;
  end

  // stage W: the entry right after k is still being written, so forward it
  always_comb begin
    w_src = w_fwd_r ? prev_wr_r : crd_r;
    if (w_exit_r) begin
      w_word.hops = HOPS_W'(1);
      w_word.land = w_land_r;
    end else begin
      w_word.hops = w_src.hops + HOPS_W'(1);
      w_word.land = w_src.land;
    end
    rb_last = w_vld_r && (w_k_r == blk_lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= 1'b0;
      t_vld_r <= 1'b0;
      w_vld_r <= 1'b0;
    end else if (state_r == S_REBUILD) begin
      t_vld_r <= iss_r;
      w_vld_r <= t_vld_r;
      if (iss_r && (kj_r == blk_lo_r)) begin
        iss_r <= 1'b0;
      end
    end else begin
      iss_r   <= rb_start;
      t_vld_r <= 1'b0;
      w_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_done) begin
      blk_lo_r  <= lo_x[AW-1:0];
      blk_end_r <= end_x[IW-1:0];
      kj_r      <= AW'(end_x - XW'(1));
    end else if ((state_r == S_REBUILD) && iss_r && (kj_r != blk_lo_r)) begin
      kj_r <= kj_r - AW'(1);
    end
    t_k_r     <= kj_r;
    w_k_r     <= t_k_r;
    w_exit_r  <= t_exit;
    w_land_r  <= t_land_x[IW-1:0];
    w_fwd_r   <= (jrd_r == JUMP_W'(1));
    prev_wr_r <= w_word;
  end

  // ---------------- query ----------------
  always_comb begin
    q_sum       = {1'b0, q_total_r} + {1'b0, crd_r.hops};
    q_total_nxt = q_sum[TOTAL_W] ? TOTAL_MAX : q_sum[TOTAL_W-1:0];
    // stop when the chain fails to advance or leaves the used range
    q_stop      = (crd_r.land <= q_x_r) || (XW'(crd_r.land) >= n_x);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_x_r     <= pos_x[IW-1:0];
      q_total_r <= '0;
    end else if (state_r == S_QUERY) begin
      q_x_r     <= crd_r.land;
      q_total_r <= q_total_nxt;
    end
  end

  // ---------------- memory ports ----------------
  always_comb begin
    jm_we    = 1'b0;
    jm_waddr = pos_x[AW-1:0];
    jm_wdata = (in_ch.jump == '0) ? JUMP_W'(1) : in_ch.jump;
    if (state_r == S_CLEAR) begin
      jm_we    = 1'b1;
      jm_waddr = clr_p_r;
      jm_wdata = JUMP_W'(1);
    end else if (in_acc && (in_ch.command == CMD_WRITE) && pos_in_table) begin
      jm_we = 1'b1;
    end
  end

  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = w_k_r;
    cm_wdata = w_word;
    if (state_r == S_CLEAR) begin
      cm_we    = 1'b1;
      cm_waddr = clr_p_r;
      cm_wdata = clr_word;
    end else if ((state_r == S_REBUILD) && w_vld_r) begin
      cm_we = 1'b1;
    end
  end

  always_comb begin
    case (state_r)
      S_REBUILD: cm_raddr = t_x[AW-1:0];
      S_QUERY:   cm_raddr = crd_r.land[AW-1:0];
      default:   cm_raddr = pos_x[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (jm_we) begin
      jump_mem[jm_waddr] <= jm_wdata;
    end
    jrd_r <= jump_mem[kj_r];
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      chain_mem[cm_waddr] <= cm_wdata;
    end
    crd_r <= chain_mem[cm_raddr];
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_WRITE) begin
            state_nxt = pos_in_table ? S_DIV : S_IDLE;
          end else begin
            state_nxt = pos_in_use ? S_QUERY : S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = rb_start ? S_REBUILD : S_IDLE;
      end
      S_REBUILD: begin
        if (rb_last) state_nxt = S_IDLE;
      end
      S_QUERY: begin
        if (q_stop) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- output register ----------------
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_r <= q_total_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.jump_total = out_total_r;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the blocked jump chain counter. Sends query and
// write items through bursty valid/ready traffic, keeps its own copy of the
// jump table and chain fields, and checks every jump_total in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bjcc_pkg::*;

  localparam int DEPTH          = TABLE_DEPTH_DEF;
  localparam int DRAIN_CYCLES   = 1200;   // covers the longest write, a full-block rebuild
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  bjcc_in_if  in_ch();
  bjcc_out_if out_ch();

  blocked_jump_chain_counter #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // mirror of the block's registers and tables
  logic [REG_W-1:0]    entry_count_reg;
  logic [REG_W-1:0]    block_size_reg;
  logic [JUMP_W-1:0]   jump_len  [DEPTH];
  logic [HOPS_W-1:0]   hops_left [DEPTH];
  logic [11:0]         exit_pos  [DEPTH];

  logic [TOTAL_W-1:0]  pending_totals[$];
  int                  err_count;
  int                  idle_cycles;
  int                  burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned used_entries();
    return (32'(entry_count_reg) > DEPTH) ? DEPTH : 32'(entry_count_reg);
  endfunction

  function automatic int unsigned block_len();
    if (block_size_reg == '0) return 1;
    return (32'(block_size_reg) > DEPTH) ? DEPTH : 32'(block_size_reg);
  endfunction

  // rebuild the block that holds pos, right end first
  function automatic void rebuild_chain_block(int unsigned pos);
    int unsigned n, bs, lo, hi, k, t;
    n  = used_entries();
    bs = block_len();
    lo = (pos / bs) * bs;
    hi = lo + bs;
    if (hi > n) hi = n;
    k = hi;
    while (k > lo) begin
      k--;
      t = k + 32'(jump_len[k]);
      if (t >= hi) begin
        hops_left[k] = HOPS_W'(1);
        exit_pos[k]  = 12'((t > n) ? n : t);
      end else begin
        hops_left[k] = hops_left[t] + HOPS_W'(1);
        exit_pos[k]  = exit_pos[t];
      end
    end
  endfunction

  function automatic logic [TOTAL_W-1:0] chain_total(int unsigned pos);
    int unsigned n, x, nx, total, steps;
    n     = used_entries();
    x     = pos;
    total = 0;
    steps = 0;
    while (x < n && steps < DEPTH) begin
      nx    = 32'(exit_pos[x]);
      total = total + 32'(hops_left[x]);
      if (total > 32'(TOTAL_MAX)) total = 32'(TOTAL_MAX);
      // stale chain fields may point backward
      if (nx <= x) break;
      x = nx;
      steps++;
    end
    return TOTAL_W'(total);
  endfunction

  function automatic void reset_chain_state();
    int unsigned p;
    entry_count_reg = REG_W'(RST_ENTRY_COUNT);
    block_size_reg  = REG_W'(RST_BLOCK_SIZE);
    for (p = 0; p < DEPTH; p++) begin
      jump_len[p]  = JUMP_W'(1);
      hops_left[p] = '0;
      exit_pos[p]  = '0;
    end
    for (p = 0; p < used_entries(); p += block_len()) rebuild_chain_block(p);
  endfunction

  function automatic void apply_item(logic cmd, logic [POS_W-1:0] pos,
                                     logic [JUMP_W-1:0] jmp);
    if (cmd == CMD_QUERY) begin
      pending_totals.push_back(chain_total(32'(pos)));
    end else begin
      jump_len[pos] = (jmp == '0) ? JUMP_W'(1) : jmp;
      rebuild_chain_block(32'(pos));
    end
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (used_entries() != 0 && $urandom_range(0, 9) != 0)
      return POS_W'($urandom_range(0, used_entries() - 1));
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic logic [JUMP_W-1:0] pick_jump();
    int unsigned sel, span;
    sel  = $urandom_range(0, 19);
    span = 2 * block_len() + 1;
    if (span > 2047) span = 2047;
    if (sel < 12) return JUMP_W'($urandom_range(1, span));
    if (sel < 17) return JUMP_W'($urandom_range(1, used_entries() + 1));
    if (sel < 19) return JUMP_W'($urandom_range(0, 2047));
    return ($urandom_range(0, 1) == 1) ? '1 : '0;
  endfunction

  // send one item; the sender runs in bursts with random gaps between them
  task automatic send_item(logic cmd, logic [POS_W-1:0] pos, logic [JUMP_W-1:0] jmp);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid    = 1'b1;
    in_ch.command  = cmd;
    in_ch.position = pos;
    in_ch.jump     = jmp;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(cmd, pos, jmp);
  endtask

  // drop valid, drain all results, then let a pending rebuild finish
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_totals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = REG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ENTRY_COUNT) entry_count_reg = REG_W'(value);
    else block_size_reg = REG_W'(value);
  endtask

  task automatic set_regs(int unsigned count, int unsigned bsize);
    settle();
    write_reg(CFG_ENTRY_COUNT, count);
    write_reg(CFG_BLOCK_SIZE, bsize);
  endtask

  task automatic rewrite_table();
    int unsigned p;
    for (p = 0; p < used_entries(); p++) send_item(CMD_WRITE, POS_W'(p), pick_jump());
  endtask

  task automatic random_items(int count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 1) send_item(CMD_QUERY, pick_pos(), pick_jump());
      else send_item(CMD_WRITE, pick_pos(), pick_jump());
    end
  endtask

  task automatic run_phase(int unsigned count, int unsigned bsize, int items, bit rewrite);
    set_regs(count, bsize);
    if (rewrite) rewrite_table();
    random_items(items);
  endtask

  // reset table, zero jump, jump past the end, field extremes
  task automatic test_reset_chain();
    send_item(CMD_QUERY, 10'd0,    11'd0);
    send_item(CMD_QUERY, 10'd1023, 11'h7ff);
    send_item(CMD_QUERY, 10'd32,   11'd0);
    send_item(CMD_WRITE, 10'd0,    11'd0);
    send_item(CMD_QUERY, 10'd0,    11'd0);
    send_item(CMD_WRITE, 10'd5,    11'h7ff);
    send_item(CMD_QUERY, 10'd0,    11'd0);
    send_item(CMD_WRITE, 10'd1023, 11'd1024);
    send_item(CMD_QUERY, 10'd1023, 11'd0);
    send_item(CMD_WRITE, 10'd512,  11'h2aa);
    send_item(CMD_QUERY, 10'd500,  11'd0);
    send_item(CMD_WRITE, 10'd33,   11'h555);
    send_item(CMD_QUERY, 10'd0,    11'd0);
    send_item(CMD_QUERY, 10'd33,   11'd0);
  endtask

  // oversized and zero registers, out-of-range queries and writes
  task automatic test_register_corners();
    set_regs(2047, 0);
    send_item(CMD_QUERY, 10'd0,   11'd0);
    send_item(CMD_WRITE, 10'd10,  11'd3);
    send_item(CMD_QUERY, 10'd0,   11'd0);
    set_regs(0, 2047);
    send_item(CMD_QUERY, 10'd0,   11'd0);
    send_item(CMD_QUERY, 10'd1023, 11'd0);
    send_item(CMD_WRITE, 10'd7,   11'd5);
    set_regs(100, 1024);
    send_item(CMD_QUERY, 10'd500, 11'd0);
    send_item(CMD_WRITE, 10'd700, 11'd2);
    send_item(CMD_QUERY, 10'd0,   11'd0);
  endtask

  // queries and writes on chain fields left over from an older layout
  task automatic test_stale_chain();
    set_regs(150, 7);
    random_items(30);
    rewrite_table();
    random_items(40);
  endtask

  task automatic test_random_tables();
    run_phase(RST_ENTRY_COUNT, RST_BLOCK_SIZE, 70, 1'b0);
    run_phase(100, 11, 150, 1'b1);
    run_phase(300, 1, 80, 1'b1);
    run_phase(2047, 2047, 40, 1'b0);
    run_phase(1, 0, 20, 1'b1);
    run_phase(0, 5, 15, 1'b0);
    run_phase(37, 6, 200, 1'b1);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ENTRY_COUNT;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_QUERY;
    in_ch.position = '0;
    in_ch.jump     = '0;
    err_count      = 0;
    burst_left     = 0;
    reset_chain_state();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_reset_chain();
    test_register_corners();
    test_random_tables();
    test_stale_chain();
    settle();

    if (pending_totals.size() != 0) begin
      $display("%0t: %0d expected jump_total items never arrived", $time,
               pending_totals.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver stalls on its own pattern, switching to a random mode after each random run
  initial begin
    int mode, run, tick;
    out_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(50, 400);
      repeat (run) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: begin
            out_ch.ready = 1'b1;
          end
          1: begin
            out_ch.ready = ($urandom_range(0, 1) == 1);
          end
          2: begin
            out_ch.ready = ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ch.ready = ((tick / 8) % 2 == 1);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    logic [TOTAL_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected jump_total item, expected none, actual %0d",
                 $time, out_ch.jump_total);
        err_count++;
      end else begin
        want = pending_totals.pop_front();
        if (out_ch.jump_total !== want) begin
          $display("%0t: jump_total mismatch, expected %0d, actual %0d",
                   $time, want, out_ch.jump_total);
          err_count++;
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

/* sim.f */
src/bjcc_pkg.sv
src/bjcc_if.sv
src/bjcc_rem_div.sv
src/blocked_jump_chain_counter.sv
dv/tb_top.sv
